@@ rtl/nidv_pkg.sv @@
// shared types, constants and the check character table for the identity code validator
package nidv_pkg;

  localparam int unsigned CodeLen = 11;
  localparam int unsigned PosMax  = 15;
  localparam int unsigned PosW    = 4;

  localparam logic [3:0] PosCentury = 4'd6;
  localparam logic [3:0] PosCheck   = 4'd10;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharA     = 8'h41;

  typedef enum logic [1:0] {
    CENT_1800 = 2'd0,
    CENT_1900 = 2'd1,
    CENT_2000 = 2'd2,
    CENT_BAD  = 2'd3
  } century_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } req_t;

  typedef struct packed {
    logic code_valid;
    logic temporary_code;
    logic is_female;
  } res_t;

  // expected check character for a remainder 0..30
  function automatic logic [7:0] check_char(input logic [4:0] idx);
    logic [7:0] c;
    unique case (idx)
      5'd0:  c = "0";
      5'd1:  c = "1";
      5'd2:  c = "2";
      5'd3:  c = "3";
      5'd4:  c = "4";
      5'd5:  c = "5";
      5'd6:  c = "6";
      5'd7:  c = "7";
      5'd8:  c = "8";
      5'd9:  c = "9";
      5'd10: c = "A";
      5'd11: c = "B";
      5'd12: c = "C";
      5'd13: c = "D";
      5'd14: c = "E";
      5'd15: c = "F";
      5'd16: c = "H";
      5'd17: c = "J";
      5'd18: c = "K";
      5'd19: c = "L";
      5'd20: c = "M";
      5'd21: c = "N";
      5'd22: c = "P";
      5'd23: c = "R";
      5'd24: c = "S";
      5'd25: c = "T";
      5'd26: c = "U";
      5'd27: c = "V";
      5'd28: c = "W";
      5'd29: c = "X";
      5'd30: c = "Y";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/national_id_code_validator.sv @@
// identity code validator: per-character field capture, mod-31 check and final date check
//
// Takes one character per cycle with no gaps needed between codes. Each accepted
// character updates the position, the running modulo-31 remainder and the date and
// individual number fields. The word that carries the last-character flag
// snapshots those fields into a check stage; the date, length and check character
// decision is registered in the result register when that stage advances.
// Input is stalled only when the check stage is full and the result register
// cannot drain.
module national_id_code_validator (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  nidv_pkg::req_t req,
  output logic           res_valid,
  input  logic           res_ready,
  output nidv_pkg::res_t res
);
  import nidv_pkg::*;

  typedef struct packed {
    logic       len_ok;
    logic       format_ok;
    century_t   century;
    logic [6:0] day;
    logic [6:0] month;
    logic [6:0] year;
    logic [9:0] indiv;
    logic       check_ok;
  } snap_t;

  // per-code state
  logic [PosW-1:0] pos, pos_next;
  logic [4:0]      remainder, remainder_next;
  logic [6:0]      day, day_next;
  logic [6:0]      month, month_next;
  logic [6:0]      year, year_next;
  century_t        century, century_next;
  logic [9:0]      indiv, indiv_next;
  logic            format_ok, format_ok_next;
  logic            check_ok, check_ok_next;

  // check stage
  logic  snap_valid;
  snap_t snap;
  logic  snap_adv;

  logic       accept;
  logic       is_digit;
  logic [3:0] digit;
  logic       digit_pos;
  logic [8:0] rem_sum;
  logic [13:0] rem_prod;
  logic [3:0] rem_q;
  logic [8:0] rem_diff;

  assign accept    = req_valid && req_ready;
  assign snap_adv  = snap_valid && (!res_valid || res_ready);
  assign req_ready = !snap_valid || snap_adv;

  assign is_digit  = (req.char_code >= CharZero) && (req.char_code <= CharNine);
  assign digit     = is_digit ? 4'(req.char_code - CharZero) : 4'd0;
  assign digit_pos = (pos <= 4'd5) || ((pos >= 4'd7) && (pos <= 4'd9));

  // (r*10 + d) mod 31 via reciprocal 33/1024, then one correction step
  assign rem_sum  = 9'(remainder) * 9'd10 + 9'(digit);
  assign rem_prod = 14'(rem_sum) * 14'd33;
  assign rem_q    = rem_prod[13:10];
  assign rem_diff = rem_sum - 9'(rem_q) * 9'd31;

  always_comb begin
    remainder_next = remainder;
    day_next       = day;
    month_next     = month;
    year_next      = year;
    century_next   = century;
    indiv_next     = indiv;
    format_ok_next = format_ok;
    check_ok_next  = check_ok;
    if (digit_pos) begin
      if (!is_digit) begin
        format_ok_next = 1'b0;
      end
      remainder_next = (rem_diff >= 9'd31) ? 5'(rem_diff - 9'd31) : rem_diff[4:0];
      priority if (pos <= 4'd1) begin
        day_next = 7'(11'(day) * 11'd10 + 11'(digit));
      end else if (pos <= 4'd3) begin
        month_next = 7'(11'(month) * 11'd10 + 11'(digit));
      end else if (pos <= 4'd5) begin
        year_next = 7'(11'(year) * 11'd10 + 11'(digit));
      end else begin
        indiv_next = 10'(14'(indiv) * 14'd10 + 14'(digit));
      end
    end else if (pos == PosCentury) begin
      priority if (req.char_code == CharPlus) begin
        century_next = CENT_1800;
      end else if (req.char_code == CharMinus) begin
        century_next = CENT_1900;
      end else if (req.char_code == CharA) begin
        century_next = CENT_2000;
      end else begin
        century_next = CENT_BAD;
      end
    end else if (pos == PosCheck) begin
      check_ok_next = (req.char_code == check_char(remainder));
    end
    pos_next = (pos < PosW'(PosMax)) ? pos + 1'b1 : pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      remainder <= '0;
      day       <= '0;
      month     <= '0;
      year      <= '0;
      century   <= CENT_1800;
      indiv     <= '0;
      format_ok <= 1'b1;
      check_ok  <= 1'b0;
    end else if (accept) begin
      if (req.last_char) begin
        pos       <= '0;
        remainder <= '0;
        day       <= '0;
        month     <= '0;
        year      <= '0;
        century   <= CENT_1800;
        indiv     <= '0;
        format_ok <= 1'b1;
        check_ok  <= 1'b0;
      end else begin
        pos       <= pos_next;
        remainder <= remainder_next;
        day       <= day_next;
        month     <= month_next;
        year      <= year_next;
        century   <= century_next;
        indiv     <= indiv_next;
        format_ok <= format_ok_next;
        check_ok  <= check_ok_next;
      end
    end
  end

  // snapshot of a finished code
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (accept && req.last_char) begin
      snap_valid <= 1'b1;
    end else if (snap_adv) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && req.last_char) begin
      snap.len_ok    <= (pos_next == PosW'(CodeLen));
      snap.format_ok <= format_ok_next;
      snap.century   <= century_next;
      snap.day       <= day_next;
      snap.month     <= month_next;
      snap.year      <= year_next;
      snap.indiv     <= indiv_next;
      snap.check_ok  <= check_ok_next;
    end
  end

  // final decision
  logic       leap;
  logic [4:0] month_days;
  logic       valid_now;
  res_t       res_next;

  always_comb begin
    // year is a multiple of 100 only when the two-digit year is zero
    if (snap.year == 7'd0) begin
      leap = (snap.century == CENT_2000);
    end else begin
      leap = (snap.year[1:0] == 2'b00);
    end
    if (snap.month == 7'd2) begin
      month_days = leap ? 5'd29 : 5'd28;
    end else if ((snap.month == 7'd4) || (snap.month == 7'd6) ||
                 (snap.month == 7'd9) || (snap.month == 7'd11)) begin
      month_days = 5'd30;
    end else begin
      month_days = 5'd31;
    end
    valid_now = snap.len_ok && snap.format_ok && (snap.century != CENT_BAD) &&
                (snap.month >= 7'd1) && (snap.month <= 7'd12) &&
                (snap.indiv >= 10'd2) && snap.check_ok &&
                (snap.day >= 7'd1) && (snap.day <= 7'(month_days));
    res_next.code_valid     = valid_now;
    res_next.temporary_code = valid_now && (snap.indiv >= 10'd900);
    res_next.is_female      = valid_now && !snap.indiv[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (snap_adv) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_adv) begin
      res <= res_next;
    end
  end

  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    accept && req.last_char |=> (pos == '0) && format_ok && (remainder == '0))
    else $error("state not cleared after last character");

  a_idle_state_clean: assert property (@(posedge clk) disable iff (rst)
    (pos == '0) |-> format_ok && !check_ok && (remainder == '0))
    else $error("fresh code starts with stale state");

  a_snap_held: assert property (@(posedge clk) disable iff (rst)
    snap_valid && !snap_adv |=> snap_valid && $stable(snap))
    else $error("pending code lost while output stalled");

  a_flags_need_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.temporary_code || res.is_female) |-> res.code_valid)
    else $error("flags reported on an invalid code");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !snap_valid |-> req_ready)
    else $error("input stalled with empty check stage");

endmodule

@@ sim/id_code_checker.sv @@
// scoreboard for the identity code validator: predicts each verdict word and checks it
module id_code_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_ready,
  input  nidv_pkg::req_t req,
  input  logic           res_valid,
  input  logic           res_ready,
  input  nidv_pkg::res_t res,
  output int             errors,
  output int             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import nidv_pkg::*;

  // check characters for remainders 0..30, first one in the top byte
  localparam logic [8*31-1:0] CheckChars = "0123456789ABCDEFHJKLMNPRSTUVWXY";

  logic [3:0] at_pos;
  logic [4:0] rem31;
  logic [6:0] day_v;
  logic [6:0] mon_v;
  logic [6:0] yr_v;
  century_t   cent;
  logic [9:0] indiv;
  logic       fmt_ok;
  logic       chk_ok;
  res_t       verdicts[$];

  function automatic int month_len(input int m, input int y);
    bit leap;
    leap = (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
    if (m == 2) return leap ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  task automatic clear_code;
    at_pos = '0;
    rem31  = '0;
    day_v  = '0;
    mon_v  = '0;
    yr_v   = '0;
    cent   = CENT_1800;
    indiv  = '0;
    fmt_ok = 1'b1;
    chk_ok = 1'b0;
  endtask

  task automatic absorb_char(input req_t w);
    logic [7:0] c;
    int         d;
    int         acc;
    int         full_year;
    bit         is_dig;
    bit         ok;
    res_t       v;
    c = w.char_code;
    is_dig = c >= CharZero && c <= CharNine;
    d = is_dig ? int'(c - CharZero) : 0;
    if (at_pos <= 5 || (at_pos >= 7 && at_pos <= 9)) begin
      // a non-digit still shifts the fields, adding zero
      if (!is_dig) fmt_ok = 1'b0;
      acc = (int'(rem31) * 10 + d) % 31;
      rem31 = acc[4:0];
      if (at_pos <= 1) begin
        acc = int'(day_v) * 10 + d;
        day_v = acc[6:0];
      end else if (at_pos <= 3) begin
        acc = int'(mon_v) * 10 + d;
        mon_v = acc[6:0];
      end else if (at_pos <= 5) begin
        acc = int'(yr_v) * 10 + d;
        yr_v = acc[6:0];
      end else begin
        acc = int'(indiv) * 10 + d;
        indiv = acc[9:0];
      end
    end else if (at_pos == PosCentury) begin
      cent = (c == CharPlus)  ? CENT_1800 :
             (c == CharMinus) ? CENT_1900 :
             (c == CharA)     ? CENT_2000 : CENT_BAD;
    end else if (at_pos == PosCheck) begin
      chk_ok = (c == CheckChars[8 * (30 - int'(rem31)) +: 8]);
    end
    // past the eleventh character only the count moves, and it stops at 15
    if (int'(at_pos) < PosMax) at_pos = at_pos + 1'b1;
    if (w.last_char) begin
      full_year = 1800 + 100 * int'(cent) + int'(yr_v);
      ok = int'(at_pos) == CodeLen && fmt_ok && cent != CENT_BAD &&
           mon_v >= 1 && mon_v <= 12 && indiv >= 2 && chk_ok && day_v >= 1 &&
           int'(day_v) <= month_len(int'(mon_v), full_year);
      v.code_valid     = ok;
      v.temporary_code = ok && indiv >= 900;
      v.is_female      = ok && !indiv[0];
      verdicts.push_back(v);
      clear_code();
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      clear_code();
      verdicts.delete();
      errors = 0;
    end else begin
      if (req_valid && req_ready) absorb_char(req);
      if (res_valid && res_ready) begin
        if (verdicts.size() == 0) begin
          $display("%0t: unexpected verdict word, expected none, actual %b", $time, res);
          errors++;
        end else begin
          want = verdicts.pop_front();
          if (res.code_valid !== want.code_valid) begin
            $display("%0t: code_valid expected %b actual %b", $time, want.code_valid,
                     res.code_valid);
            errors++;
          end
          if (res.temporary_code !== want.temporary_code) begin
            $display("%0t: temporary_code expected %b actual %b", $time,
                     want.temporary_code, res.temporary_code);
            errors++;
          end
          if (res.is_female !== want.is_female) begin
            $display("%0t: is_female expected %b actual %b", $time, want.is_female,
                     res.is_female);
            errors++;
          end
        end
      end
    end
    pending = verdicts.size();
  end

endmodule

@@ sim/tb_top.sv @@
// bench top for the identity code validator: clock, reset, code stimulus and verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import nidv_pkg::*;

  typedef logic [7:0] char_q_t[$];

  logic    clk;
  logic    rst;
  logic    req_valid;
  logic    req_ready;
  req_t    req;
  logic    res_valid;
  logic    res_ready;
  res_t    res;
  int      errors;
  int      pending;

  int      burst_left = 0;
  bit      steady = 1'b0;
  int      chars_sent = 0;
  int      codes_sent = 0;

  national_id_code_validator dut (
    .clk, .rst, .req_valid, .req_ready, .req, .res_valid, .res_ready, .res
  );

  id_code_checker verdict_chk (
    .clk, .rst, .req_valid, .req_ready, .req, .res_valid, .res_ready, .res,
    .errors, .pending
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // DDMMYY, sign, NNN, then the matching check character
  function automatic char_q_t make_code(input int day, input int mon, input int yr,
                                        input logic [7:0] sign, input int num);
    char_q_t         q;
    longint unsigned n;
    longint unsigned div;
    logic [7:0]      ch;
    logic [4:0]      r;
    n = longint'(day) * 10000000 + longint'(mon) * 100000 + longint'(yr) * 1000 + num;
    div = 100000000;
    repeat (9) begin
      if (div == 100) q.push_back(sign);
      ch = CharZero + 8'((n / div) % 10);
      q.push_back(ch);
      div = div / 10;
    end
    r = 5'(n % 31);
    q.push_back(check_char(r));
    return q;
  endfunction

  task automatic send_word(input req_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        req_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    req = w;
    req_valid = 1'b1;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
    burst_left--;
    chars_sent++;
  endtask

  task automatic send_code(input char_q_t chars);
    req_t w;
    foreach (chars[i]) begin
      w.char_code = chars[i];
      w.last_char = (i == chars.size() - 1);
      send_word(w);
    end
    codes_sent++;
  endtask

  task automatic wait_for_verdicts;
    req_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // receiver: open stretches, long stalls and single random cycles
  initial begin
    int unsigned hold;
    bit          lvl;
    hold = 0;
    lvl = 1'b0;
    res_ready = 1'b0;
    forever begin
      if (hold == 0) begin
        case ($urandom_range(0, 3))
          0: begin
            lvl = 1'b1;
            hold = $urandom_range(20, 80);
          end
          1: begin
            lvl = 1'b0;
            hold = $urandom_range(1, 20);
          end
          default: begin
            lvl = $urandom_range(0, 1);
            hold = 1;
          end
        endcase
      end
      res_ready = lvl;
      hold--;
      @(negedge clk);
    end
  end

  initial begin
    char_q_t    code;
    int         kind;
    int         pick;
    int         day;
    int         mon;
    int         num;
    logic [7:0] sign;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_code(make_code(13, 10, 52, CharMinus, 308));
    send_code(make_code(29, 2, 0, CharA, 902));       // leap day of 2000, temporary
    send_code(make_code(29, 2, 0, CharMinus, 124));   // 1900 is not a leap year
    send_code(make_code(0, 5, 99, CharPlus, 2));      // day zero
    send_code(make_code(31, 12, 99, CharPlus, 999));
    send_code(make_code(1, 13, 50, CharA, 40));       // month out of range
    send_code(make_code(30, 4, 20, CharA, 1));        // individual number too low
    send_code(make_code(15, 6, 70, 8'h42, 500));      // bad century sign
    code = make_code(12, 3, 45, CharMinus, 77);
    code[3] = 8'h78;                                  // letter in a digit slot
    send_code(code);
    send_code('{8'h37});                              // lone last character
    code = make_code(12, 3, 45, CharMinus, 77);
    repeat (5) code.push_back(8'hFF);                 // overlong, count saturates
    send_code(code);
    wait_for_verdicts();

    while (chars_sent < 400) begin
      if ($urandom_range(0, 7) == 0) steady = !steady;
      pick = $urandom_range(0, 15);
      sign = (pick < 5) ? CharPlus : (pick < 10) ? CharMinus : (pick < 15) ? CharA :
             8'($urandom_range(0, 255));
      day = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 28) : $urandom_range(0, 31);
      mon = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 12) : $urandom_range(0, 15);
      num = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 999);
      code = make_code(day, mon, $urandom_range(0, 99), sign, num);
      kind = $urandom_range(0, 99);
      if (kind >= 88) begin
        code = {};
        repeat ($urandom_range(1, 14)) code.push_back(8'($urandom_range(0, 255)));
      end else if (kind >= 80) begin
        repeat ($urandom_range(1, 6)) code.push_back(8'($urandom_range(0, 255)));
      end else if (kind >= 70) begin
        repeat ($urandom_range(1, 10)) void'(code.pop_back());
      end else if (kind >= 58) begin
        code[$urandom_range(0, 10)] = 8'($urandom_range(0, 255));
      end
      send_code(code);
      if (codes_sent == 30) wait_for_verdicts();
    end

    wait_for_verdicts();
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

@@ files.f @@
rtl/nidv_pkg.sv
rtl/national_id_code_validator.sv
sim/id_code_checker.sv
sim/tb_top.sv
